@@ hdl/uhd_pkg.sv @@
// Shared types, constants and helpers for the ultrasonic height detector.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package uhd_pkg;

  // Field widths
  localparam int EchoW   = 16;
  localparam int DistW   = 11;
  localparam int HeightW = 12;
  localparam int CountW  = 4;
  localparam int ProdW   = 24;   // echo * 153 fits in 24 bits
  localparam int RecipW  = 25;
  localparam int RecipSh = 37;

  // Conversion constants: dist = floor(us * 153 / 5800)
  localparam logic [7:0]        EchoScale = 8'd153;
  // ceil(2^37 / 5800): exact floor division for every 24-bit dividend
  localparam logic [RecipW-1:0] RecipMul  = 25'd23696372;

  // Configuration port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] CFG_IDX_CALIBRATE = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_MATCHES   = 4'd1;

  // Reset values
  localparam logic [CountW-1:0]         MatchesReset  = 4'd5;
  localparam logic signed [HeightW-1:0] PrevHeightRst = -12'sd1;
  localparam logic signed [HeightW-1:0] LastDetRst    = -12'sd99;
  localparam logic signed [HeightW-1:0] HeightMin     = -12'sd2048;
  localparam logic signed [HeightW-1:0] HeightMax     = 12'sd2047;
  localparam logic [CountW-1:0]         CountMax      = 4'd15;

  typedef logic [DistW-1:0]          dist_t;
  typedef logic signed [HeightW-1:0] height_t;

  typedef struct packed {
    logic              calibrate_mode;
    logic [CountW-1:0] required_matches;
  } cfg_t;

  // Saturate a 13-bit signed value to 12-bit signed.
  function automatic height_t sat12(input logic signed [HeightW:0] v);
    height_t r;
    if (v < 13'(signed'(HeightMin))) begin
      r = HeightMin;
    end else if (v > 13'(signed'(HeightMax))) begin
      r = HeightMax;
    end else begin
      r = v[HeightW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ultrasonic_height_detector_top.sv @@
// Ultrasonic height detector with a stability filter: a user sees the stream ports here.
// Top level; instantiates uhd_front, uhd_queue and uhd_back, uses uhd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each slave transaction carries one echo width in microseconds (0 means a
// timeout) and yields exactly one master transaction with the distance in cm,
// floor(us*153/5800), falling back to the last nonzero distance, the height
// (base minus distance, saturated to 12-bit signed), and a detection flag with
// the detected height. The block takes one transaction per cycle sustained
// while the master side accepts every cycle. A result passes four registers:
// the two multiplier stages of the front end, the queue and the output
// register of the filter. The first is loaded at the accepting edge, and the
// result is presented on the master side once the output register holds it.
// Configuration writes on the cfg channel are always taken; issue them only
// while no transaction is in flight. Register 0 is calibrate_mode, register 1
// is required_matches; other indexes are ignored.

module ultrasonic_height_detector_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Echo input
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [15:0]                  s_tdata,   // [15:0] echo_duration_us
  // Result output
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [39:0]                       m_tdata,   // [10:0] distance_cm,
                                                       // [22:11] height_cm,
                                                       // [34:23] detected_cm,
                                                       // [39:35] zero
  output logic                              m_tuser,   // [0] detect_valid
  // Configuration writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [uhd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [uhd_pkg::CfgDataW-1:0] cfg_data
);

  uhd_pkg::cfg_t    cfg;
  logic             fq_valid;
  logic             fq_ready;
  uhd_pkg::dist_t   fq_dist;
  logic             qb_valid;
  logic             qb_ready;
  uhd_pkg::dist_t   qb_dist;
  uhd_pkg::dist_t   res_dist;
  uhd_pkg::height_t res_height;
  uhd_pkg::height_t res_detected;

  // Configuration registers: take every write, drop unknown indexes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.calibrate_mode   <= 1'b0;
      cfg.required_matches <= uhd_pkg::MatchesReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        uhd_pkg::CFG_IDX_CALIBRATE: cfg.calibrate_mode   <= cfg_data[0];
        uhd_pkg::CFG_IDX_MATCHES:   cfg.required_matches <= cfg_data[uhd_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Front end: echo width to centimetres
  uhd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_echo   (s_tdata),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_dist  (fq_dist)
  );

  // Queue: lets the front end keep going while the output stalls
  uhd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_dist   (fq_dist),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_dist  (qb_dist)
  );

  // Back end: filter, detection and output register
  uhd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (qb_valid),
    .in_ready     (qb_ready),
    .in_dist      (qb_dist),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_dist     (res_dist),
    .out_height   (res_height),
    .out_detect   (m_tuser),
    .out_detected (res_detected)
  );

  // Pack the result, lowest field first, padded to whole bytes
  assign m_tdata = {5'b00000, res_detected, res_height, res_dist};

endmodule

`default_nettype wire

@@ hdl/uhd_front.sv @@
// Front end: accepts echo widths and converts them to centimetres.
// Two multiplier stages; uses uhd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uhd_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [uhd_pkg::EchoW-1:0] in_echo,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output uhd_pkg::dist_t                 out_dist
);

  logic                        s1_valid;
  logic [uhd_pkg::ProdW-1:0]   s1_prod;
  logic                        s2_valid;
  uhd_pkg::dist_t              s2_dist;
  logic                        en1;
  logic                        en2;
  logic [48:0]                 recip_prod;

  assign en2      = !s2_valid || out_ready;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  assign recip_prod = 49'(s1_prod) * 49'(uhd_pkg::RecipMul);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_prod <= uhd_pkg::ProdW'(in_echo) * uhd_pkg::ProdW'(uhd_pkg::EchoScale);
    end
    if (en2) begin
      s2_dist <= recip_prod[uhd_pkg::RecipSh+uhd_pkg::DistW-1:uhd_pkg::RecipSh];
    end
  end

  assign out_valid = s2_valid;
  assign out_dist  = s2_dist;

endmodule

`default_nettype wire

@@ hdl/uhd_queue.sv @@
// Two-entry queue between the front end and the back end.
// Holds distances; uses uhd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uhd_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire uhd_pkg::dist_t in_dist,
  output logic          out_valid,
  input  wire logic     out_ready,
  output uhd_pkg::dist_t out_dist
);

  uhd_pkg::dist_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_dist  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= in_dist;
  end

endmodule

`default_nettype wire

@@ hdl/uhd_back.sv @@
// Back end: distance fallback, height, stability filter and detection.
// Holds the filter state and the output register; uses uhd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uhd_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire uhd_pkg::cfg_t cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire uhd_pkg::dist_t in_dist,
  output logic            out_valid,
  input  wire logic       out_ready,
  output uhd_pkg::dist_t  out_dist,
  output uhd_pkg::height_t out_height,
  output logic            out_detect,
  output uhd_pkg::height_t out_detected
);

  // Filter state
  uhd_pkg::dist_t              backup_distance;
  uhd_pkg::height_t            previous_height;
  logic [uhd_pkg::CountW-1:0]  match_count;
  uhd_pkg::height_t            held_height;
  uhd_pkg::height_t            last_detection;
  uhd_pkg::height_t            base_height;

  uhd_pkg::dist_t              backup_distance_next;
  uhd_pkg::height_t            previous_height_next;
  logic [uhd_pkg::CountW-1:0]  match_count_next;
  uhd_pkg::height_t            held_height_next;
  uhd_pkg::height_t            last_detection_next;
  uhd_pkg::height_t            base_height_next;

  uhd_pkg::dist_t              cur_dist;
  uhd_pkg::height_t            height;
  logic [uhd_pkg::CountW-1:0]  need;
  logic [uhd_pkg::CountW-1:0]  count_inc;
  logic                        fire;
  uhd_pkg::height_t            det;
  logic                        take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    backup_distance_next = backup_distance;
    previous_height_next = previous_height;
    match_count_next     = match_count;
    held_height_next     = held_height;
    last_detection_next  = last_detection;
    base_height_next     = base_height;
    fire                 = 1'b0;
    det                  = '0;

    // Fall back to the last nonzero distance on a timeout
    if (in_dist != '0) begin
      cur_dist             = in_dist;
      backup_distance_next = in_dist;
    end else begin
      cur_dist = backup_distance;
    end

    height = uhd_pkg::sat12(13'(base_height) - signed'({2'b00, cur_dist}));
    need   = (cfg.required_matches == '0) ? 4'd1 : cfg.required_matches;
    count_inc = (match_count < uhd_pkg::CountMax) ? match_count + 4'd1 : match_count;

    if (height == previous_height) begin
      held_height_next = height;
      match_count_next = count_inc;
      if (count_inc >= need) begin
        // Restart qualification whether or not this fires
        previous_height_next = uhd_pkg::PrevHeightRst;
        match_count_next     = '0;
        if (height != last_detection) begin
          fire                = 1'b1;
          det                 = height;
          last_detection_next = height;
          if (cfg.calibrate_mode) begin
            base_height_next    = uhd_pkg::sat12(-13'(height));
            last_detection_next = uhd_pkg::PrevHeightRst;
          end
        end
      end
    end else begin
      match_count_next     = '0;
      previous_height_next = height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backup_distance <= '0;
      previous_height <= uhd_pkg::PrevHeightRst;
      match_count     <= '0;
      held_height     <= '0;
      last_detection  <= uhd_pkg::LastDetRst;
      base_height     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        backup_distance <= backup_distance_next;
        previous_height <= previous_height_next;
        match_count     <= match_count_next;
        held_height     <= held_height_next;
        last_detection  <= last_detection_next;
        base_height     <= base_height_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_dist     <= cur_dist;
      out_height   <= height;
      out_detect   <= fire;
      out_detected <= det;
    end
  end

endmodule

`default_nettype wire
